// ===== design/wlr_pkg.sv =====
// Shared types, constants and the letter test for the word letter reverser.
`default_nettype none
package wlr_pkg;

    // ASCII letter bounds.
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified request as it travels from the front to the back.
    typedef struct packed {
        logic [7:0] data;
        logic       letter;
        logic       last;
    } cmd_t;

    // Back-end sequencer states. The drain states differ in what follows
    // the final pop: the delimiter byte, a new push, or the end of the run.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DRAIN_BYTE,
        S_DRAIN_PUSH,
        S_DRAIN_END,
        S_BYTE
    } back_state_t;

    function automatic logic is_letter(input logic [7:0] c);
        logic lower;
        logic upper;
        lower = (c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z);
        upper = (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z);
        return lower || upper;
    endfunction

endpackage
`default_nettype wire

// ===== design/wlr_queue.sv =====
// Short command queue that decouples the front from the back.
`default_nettype none
module wlr_queue
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire wlr_pkg::cmd_t              push_cmd,
    input  wire logic                       pop,
    output wlr_pkg::cmd_t                   head_cmd,
    output logic                            head_valid,
    output logic [wlr_pkg::QCNT_W-1:0]      count
);

    wlr_pkg::cmd_t                  entry_reg [wlr_pkg::QUEUE_DEPTH];
    logic [wlr_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [wlr_pkg::QPTR_W-1:0]     wr_ptr_next;
    logic [wlr_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [wlr_pkg::QPTR_W-1:0]     rd_ptr_next;
    logic [wlr_pkg::QCNT_W-1:0]     count_reg;
    logic [wlr_pkg::QCNT_W-1:0]     count_next;

    // Pointer advance with wrap and the fill count.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            if (wr_ptr_reg == wlr_pkg::QPTR_W'(wlr_pkg::QUEUE_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + wlr_pkg::QPTR_W'(1);
        end
        if (pop)
        begin
            if (rd_ptr_reg == wlr_pkg::QPTR_W'(wlr_pkg::QUEUE_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + wlr_pkg::QPTR_W'(1);
        end
        if (push && !pop)
            count_next = count_reg + wlr_pkg::QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - wlr_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign count      = count_reg;

endmodule
`default_nettype wire

// ===== design/wlr_front.sv =====
// Front end: accepts input requests, classifies each byte and queues it.
`default_nettype none
module wlr_front
(
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [7:0]                 in_byte,
    input  wire logic                       text_end,
    input  wire logic [wlr_pkg::QCNT_W-1:0] q_count,
    output logic                            q_push,
    output wlr_pkg::cmd_t                   q_cmd
);

    // A request is taken whenever the queue has a free entry.
    assign in_ready = (q_count != wlr_pkg::QCNT_W'(wlr_pkg::QUEUE_DEPTH));
    assign q_push   = in_valid && in_ready;

    // Classify the byte as a letter or a delimiter.
    always_comb
    begin
        q_cmd.data   = in_byte;
        q_cmd.letter = wlr_pkg::is_letter(in_byte);
        q_cmd.last   = text_end;
    end

endmodule
`default_nettype wire

// ===== design/wlr_back.sv =====
// Back end: word stack, pop sequencer and the output register.
`default_nettype none
module wlr_back
#(
    parameter int WORD_DEPTH = 32
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire wlr_pkg::cmd_t  cmd,
    input  wire logic           cmd_valid,
    output logic                cmd_pop,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [7:0]          out_byte,
    output logic                run_last,
    output logic                text_done
);

    localparam int IW = (WORD_DEPTH > 1) ? $clog2(WORD_DEPTH) : 1;
    localparam int CW = $clog2(WORD_DEPTH + 1);

    wlr_pkg::back_state_t   state_reg;
    wlr_pkg::back_state_t   state_next;
    logic [CW-1:0]          held_reg;
    logic [CW-1:0]          held_next;

    logic [7:0]             stack_mem [WORD_DEPTH];
    logic [7:0]             top_reg;
    logic                   wr_en;
    logic [IW-1:0]          wr_addr;
    logic [IW-1:0]          rd_addr;

    logic                   out_valid_reg;
    logic [7:0]             out_byte_reg;
    logic                   run_last_reg;
    logic                   text_done_reg;

    logic                   can_emit;
    logic                   emit;
    logic [7:0]             emit_byte;
    logic                   emit_run_last;
    logic                   emit_text_done;
    logic                   last_pop;

    assign can_emit = !out_valid_reg || out_ready;
    assign last_pop = (held_reg == CW'(1));

    // Sequencer: pushes letters, drains the stack newest first, emits delimiters.
    always_comb
    begin
        state_next     = state_reg;
        held_next      = held_reg;
        wr_en          = 1'b0;
        cmd_pop        = 1'b0;
        emit           = 1'b0;
        emit_byte      = top_reg;
        emit_run_last  = 1'b0;
        emit_text_done = 1'b0;
        case (state_reg)
            wlr_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.letter)
                    begin
                        if (held_reg == CW'(WORD_DEPTH))
                            state_next = wlr_pkg::S_DRAIN_PUSH;
                        else
                        begin
                            wr_en     = 1'b1;
                            held_next = held_reg + CW'(1);
                            if (cmd.last)
                                state_next = wlr_pkg::S_DRAIN_END;
                            else
                                cmd_pop = 1'b1;
                        end
                    end
                    else if (held_reg == '0)
                        state_next = wlr_pkg::S_BYTE;
                    else
                        state_next = wlr_pkg::S_DRAIN_BYTE;
                end
            end
            wlr_pkg::S_DRAIN_BYTE:
            begin
                if (can_emit)
                begin
                    emit      = 1'b1;
                    held_next = held_reg - CW'(1);
                    if (last_pop)
                        state_next = wlr_pkg::S_BYTE;
                end
            end
            wlr_pkg::S_DRAIN_PUSH:
            begin
                // The split chunk ends the request only if no final flush follows.
                if (can_emit)
                begin
                    emit      = 1'b1;
                    held_next = held_reg - CW'(1);
                    if (last_pop)
                    begin
                        emit_run_last = !cmd.last;
                        state_next    = wlr_pkg::S_IDLE;
                    end
                end
            end
            wlr_pkg::S_DRAIN_END:
            begin
                if (can_emit)
                begin
                    emit      = 1'b1;
                    held_next = held_reg - CW'(1);
                    if (last_pop)
                    begin
                        emit_run_last  = 1'b1;
                        emit_text_done = 1'b1;
                        cmd_pop        = 1'b1;
                        state_next     = wlr_pkg::S_IDLE;
                    end
                end
            end
            wlr_pkg::S_BYTE:
            begin
                if (can_emit)
                begin
                    emit           = 1'b1;
                    emit_byte      = cmd.data;
                    emit_run_last  = 1'b1;
                    emit_text_done = cmd.last;
                    cmd_pop        = 1'b1;
                    state_next     = wlr_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = wlr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wlr_pkg::S_IDLE;
            held_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            held_reg  <= held_next;
        end
    end

    // Stack addresses: the read port always tracks the entry on top.
    assign wr_addr = IW'(held_reg);
    assign rd_addr = (held_next == '0) ? '0 : IW'(held_next - CW'(1));

    // Word stack with a registered top-of-stack read and write bypass.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            stack_mem[wr_addr] <= cmd.data;
        if (wr_en && (wr_addr == rd_addr))
            top_reg <= cmd.data;
        else
            top_reg <= stack_mem[rd_addr];
    end

    // Output register: holds one result until it is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg  <= emit_byte;
            run_last_reg  <= emit_run_last;
            text_done_reg <= emit_text_done;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = run_last_reg;
    assign text_done = text_done_reg;

endmodule
`default_nettype wire

// ===== design/word_letter_reverser.sv =====
// Word letter reverser: each accepted request passes through the command queue to the back end,
// and each result is held in the output register. A plain letter is pushed on the stack; a
// delimiter or a letter that ends the text drains the held letters newest first; a letter that
// meets a full stack drains it first. Results leave at most one per cycle while out_ready is high.
// Reset is asynchronous and active low; it clears the queue, the held count and the output
// valid. Stack contents are not cleared and need no sweep.
`default_nettype none
module word_letter_reverser
#(
    parameter int WORD_DEPTH = 32
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       text_end,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            run_last,
    output logic            text_done
);

    logic                           q_push;
    wlr_pkg::cmd_t                  q_cmd;
    logic                           q_pop;
    wlr_pkg::cmd_t                  head_cmd;
    logic                           head_valid;
    logic [wlr_pkg::QCNT_W-1:0]     q_count;

    // Front end: classification.
    wlr_front u_front
    (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_byte  (in_byte),
        .text_end (text_end),
        .q_count  (q_count),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    // Command queue.
    wlr_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .pop        (q_pop),
        .head_cmd   (head_cmd),
        .head_valid (head_valid),
        .count      (q_count)
    );

    // Back end: stack and result sequencing.
    wlr_back #(
        .WORD_DEPTH (WORD_DEPTH)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (head_cmd),
        .cmd_valid (head_valid),
        .cmd_pop   (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .run_last  (run_last),
        .text_done (text_done)
    );

    // The back end never retires a request that is not in the queue.
    a_pop_needs_entry : assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> head_valid)
        else $error("back end popped an empty command queue");

    // A pop alone lowers the count by one on the next cycle.
    a_pop_count : assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && !q_push) |=> (q_count == $past(q_count) - wlr_pkg::QCNT_W'(1)))
        else $error("command queue count did not follow a pop");

    // The end of a text is always the last result of its request.
    a_done_is_last : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && text_done) |-> run_last)
        else $error("text_done raised on a result that is not run_last");

endmodule
`default_nettype wire
